// ===== rtl/wcv_pkg.sv =====
// shared types and constants of the windowed command vote block
// window geometry, command letter table and result codes; no dependencies
package wcv_pkg;

  localparam int WINDOW_LEN  = 8;
  localparam int NUM_LETTERS = 7;
  localparam int CHAR_W      = 8;
  localparam int THR_W       = 4;
  localparam int CNT_W       = $clog2(WINDOW_LEN + 1);
  localparam int CMP_W       = (CNT_W > THR_W) ? CNT_W : THR_W;
  localparam int CODE_W      = 3;

  typedef logic [CHAR_W-1:0] char_t;
  typedef logic [THR_W-1:0]  thr_t;
  typedef logic [CNT_W-1:0]  cnt_t;

  localparam char_t FILL_CHAR = 8'h30;  // ascii '0'
  localparam thr_t  THR_RESET = 4'd3;

  // command letters in priority order: t f b L r s x
  localparam char_t LETTERS [NUM_LETTERS] = '{
    8'h74, 8'h66, 8'h62, 8'h4C, 8'h72, 8'h73, 8'h78
  };

  typedef enum logic [CODE_W-1:0] {
    CMD_NONE = 3'd0,
    CMD_T    = 3'd1,
    CMD_F    = 3'd2,
    CMD_B    = 3'd3,
    CMD_L    = 3'd4,
    CMD_R    = 3'd5,
    CMD_S    = 3'd6,
    CMD_X    = 3'd7
  } cmd_code_e;

  // register index, taken from byte address bit 2
  typedef enum logic {
    REG_VOTE_THRESHOLD = 1'b0,
    REG_UNUSED         = 1'b1
  } reg_idx_e;

endpackage

// ===== rtl/windowed_command_vote.sv =====
// windowed command vote: shift window of received bytes and per-letter vote
// depends on wcv_pkg for window length, letter table and result codes
//
// an accepted byte enters the window register; its vote is then loaded into the result register
// throughput: one byte per cycle while out_stall_i is low, set by the window register and one vote stage
// the window stage and the result register hold one transaction each, so a byte
//   is still taken while a finished result waits at the output, if the window stage is empty
// reset: window entries go to ascii '0', vote_threshold to 3, both stages empty
module windowed_command_vote (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // configuration port
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [2:0]                    paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready,
  // input byte channel
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [wcv_pkg::CHAR_W-1:0]    rx_char_i,
  // result channel
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [wcv_pkg::CODE_W-1:0]    command_code_o
);
  import wcv_pkg::*;

  // configuration register
  thr_t     thr_q;
  reg_idx_e reg_idx;
  logic     cfg_wr;

  // stage 1: window register, freshly shifted byte is in place
  char_t     win_q [WINDOW_LEN];
  char_t     win_d [WINDOW_LEN];
  logic      v1_q;

  // stage 2: result register
  logic      out_v_q;
  cmd_code_e out_code_q;
  cmd_code_e code_d;

  logic      in_acc;
  logic      adv2;

  logic [WINDOW_LEN-1:0]  match [NUM_LETTERS];
  cnt_t                   cnt   [NUM_LETTERS];
  logic [NUM_LETTERS-1:0] hit;

  // ------------------------------------------------------------------
  // apb register access, single register at byte address 0
  // ------------------------------------------------------------------
  assign pready  = 1'b1;
  assign reg_idx = reg_idx_e'(paddr[2]);
  assign cfg_wr  = psel && penable && pwrite && pready
                   && (reg_idx == REG_VOTE_THRESHOLD);

  always_comb begin
    prdata = '0;
    if (reg_idx == REG_VOTE_THRESHOLD) begin
      prdata = 32'(thr_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= THR_RESET;
    end else if (cfg_wr) begin
      thr_q <= pwdata[THR_W-1:0];
    end
  end

  // ------------------------------------------------------------------
  // handshake: stage 2 moves when empty or drained, stage 1 only refills when
  // empty or when its content moves on, so the window never runs ahead of a vote
  // ------------------------------------------------------------------
  assign adv2       = !out_v_q || !out_stall_i;
  assign in_stall_o = v1_q && !adv2;
  assign in_acc     = in_valid_i && !in_stall_o;

  // oldest byte drops out at index 0, newest enters at the top
  always_comb begin
    for (int i = 0; i < WINDOW_LEN - 1; i++) begin
      win_d[i] = win_q[i+1];
    end
    win_d[WINDOW_LEN-1] = rx_char_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < WINDOW_LEN; i++) begin
        win_q[i] <= FILL_CHAR;
      end
      v1_q <= 1'b0;
    end else begin
      if (in_acc) begin
        win_q <= win_d;
      end
      if (in_acc) begin
        v1_q <= 1'b1;
      end else if (adv2) begin
        v1_q <= 1'b0;
      end
    end
  end

  // ------------------------------------------------------------------
  // vote: per-letter match vector over the window, popcount, threshold
  // compare, then the first letter in priority order that passes
  // ------------------------------------------------------------------
  always_comb begin
    for (int k = 0; k < NUM_LETTERS; k++) begin
      for (int i = 0; i < WINDOW_LEN; i++) begin
        match[k][i] = (win_q[i] == LETTERS[k]);
      end
      cnt[k] = CNT_W'($countones(match[k]));
      hit[k] = (CMP_W'(cnt[k]) >= CMP_W'(thr_q));
    end
  end

  // walk from lowest priority up so the highest priority hit wins
  always_comb begin
    code_d = CMD_NONE;
    for (int k = NUM_LETTERS - 1; k >= 0; k--) begin
      if (hit[k]) begin
        code_d = cmd_code_e'(CODE_W'(k + 1));
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (adv2) begin
      out_v_q <= v1_q;
    end
  end

  // result payload, loaded only when stage 2 moves
  always_ff @(posedge clk_i) begin
    if (adv2 && v1_q) begin
      out_code_q <= code_d;
    end
  end

  assign out_valid_o    = out_v_q;
  assign command_code_o = CODE_W'(out_code_q);

  // ------------------------------------------------------------------
  // assertions
  // ------------------------------------------------------------------

  // an empty window stage never pushes back
  a_free_stage_takes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !v1_q |-> !in_stall_o)
    else $error("input stalled with empty window stage");

  // an accepted byte always lands in the window stage
  a_accept_fills: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> v1_q)
    else $error("accepted byte lost before vote");

  // a threshold above the window length can never be met
  a_thr_high_none: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v1_q && adv2 && (CMP_W'(thr_q) > CMP_W'(WINDOW_LEN)))
    |=> (out_code_q == CMD_NONE))
    else $error("command reported above window length threshold");

  // a zero threshold always yields the top priority letter
  a_thr_zero_t: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v1_q && adv2 && (thr_q == '0)) |=> (out_code_q == CMD_T))
    else $error("zero threshold did not select letter t");

endmodule
